@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/cfifo_pkg.sv @@
// Types, constants and helpers of the circular FIFO with even purge
package cfifo_pkg;

    localparam int unsigned DEPTH  = 16;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        OP_STATUS = 2'd0,
        OP_ENQ    = 2'd1,
        OP_DEQ    = 2'd2,
        OP_PURGE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PURGE,
        ST_RESP
    } state_t;

    typedef struct packed {
        opcode_t                   opcode;
        logic signed [DATA_W-1:0]  data_in;
    } req_t;

    typedef struct packed {
        logic                      ok;
        logic signed [DATA_W-1:0]  head_value;
        logic                      head_valid;
        logic [CNT_W-1:0]          count;
        logic                      is_empty;
        logic                      is_full;
    } rsp_t;

    function automatic logic [ADDR_W-1:0] next_pos(input logic [ADDR_W-1:0] p);
        return (p == ADDR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

@@ hw/rtl/circular_fifo_with_even_purge.sv @@
// Top level of the circular FIFO of signed words with an even-value purge
// Status, enqueue and dequeue: the RAM read of the head entry is issued on acceptance,
// then ST_RESP loads the registered result beat; no new item is taken before that load.
// Purge: ST_PURGE reads each entry once, then ST_RESP loads the result; no new item is taken meanwhile.
// A new item is taken while an earlier result beat still waits on rsp_stall.
// Reset: asynchronous, clears pointers, count and handshake state; RAM contents are kept.
module circular_fifo_with_even_purge (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  cfifo_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output cfifo_pkg::rsp_t rsp
);

    cfifo_pkg::state_t                  state_reg, state_next;
    logic [cfifo_pkg::ADDR_W-1:0]       head_reg, head_next;
    logic [cfifo_pkg::ADDR_W-1:0]       tail_reg, tail_next;
    logic [cfifo_pkg::CNT_W-1:0]        count_reg, count_next;
    logic                               ok_reg, ok_next;
    logic                               fwd_reg, fwd_next;
    logic [cfifo_pkg::DATA_W-1:0]       fwd_data_reg, fwd_data_next;
    logic [cfifo_pkg::ADDR_W-1:0]       rpos_reg, rpos_next;
    logic [cfifo_pkg::ADDR_W-1:0]       wpos_reg, wpos_next;
    logic [cfifo_pkg::CNT_W-1:0]        left_reg, left_next;
    logic [cfifo_pkg::CNT_W-1:0]        kept_reg, kept_next;
    logic                               rsp_valid_reg, rsp_valid_next;
    cfifo_pkg::rsp_t                    rsp_reg, rsp_next;

    logic                               ram_we;
    logic [cfifo_pkg::ADDR_W-1:0]       ram_waddr;
    logic [cfifo_pkg::DATA_W-1:0]       ram_wdata;
    logic                               ram_re;
    logic [cfifo_pkg::ADDR_W-1:0]       ram_raddr;
    logic [cfifo_pkg::DATA_W-1:0]       ram_rdata;

    cfifo_ram #(
        .WIDTH (cfifo_pkg::DATA_W),
        .DEPTH (cfifo_pkg::DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfifo_pkg::ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            ok_reg        <= 1'b0;
            fwd_reg       <= 1'b0;
            rpos_reg      <= '0;
            wpos_reg      <= '0;
            left_reg      <= '0;
            kept_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            ok_reg        <= ok_next;
            fwd_reg       <= fwd_next;
            rpos_reg      <= rpos_next;
            wpos_reg      <= wpos_next;
            left_reg      <= left_next;
            kept_reg      <= kept_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= fwd_data_next;
        rsp_reg      <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        ok_next        = ok_reg;
        fwd_next       = fwd_reg;
        fwd_data_next  = fwd_data_reg;
        rpos_next      = rpos_reg;
        wpos_next      = wpos_reg;
        left_next      = left_reg;
        kept_next      = kept_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        ram_we         = 1'b0;
        ram_waddr      = tail_reg;
        ram_wdata      = req.data_in;
        ram_re         = 1'b0;
        ram_raddr      = head_reg;
        req_stall      = (state_reg != cfifo_pkg::ST_IDLE);

        unique case (state_reg)
            cfifo_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    ok_next    = 1'b1;
                    fwd_next   = 1'b0;
                    state_next = cfifo_pkg::ST_RESP;
                    ram_re     = 1'b1;
                    unique case (req.opcode)
                        cfifo_pkg::OP_ENQ:
                        begin
                            if (count_reg == cfifo_pkg::FULL_COUNT)
                            begin
                                ok_next = 1'b0;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                tail_next  = cfifo_pkg::next_pos(tail_reg);
                                count_next = count_reg + 1'b1;
                                if (count_reg == '0)
                                begin
                                    fwd_next      = 1'b1;
                                    fwd_data_next = req.data_in;
                                end
                            end
                        end
                        cfifo_pkg::OP_DEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                ok_next = 1'b0;
                            end
                            else
                            begin
                                head_next  = cfifo_pkg::next_pos(head_reg);
                                count_next = count_reg - 1'b1;
                                ram_raddr  = cfifo_pkg::next_pos(head_reg);
                            end
                        end
                        cfifo_pkg::OP_PURGE:
                        begin
                            head_next = tail_reg;
                            if (count_reg != '0)
                            begin
                                state_next = cfifo_pkg::ST_PURGE;
                                head_next  = head_reg;
                                rpos_next  = cfifo_pkg::next_pos(head_reg);
                                left_next  = count_reg - 1'b1;
                                wpos_next  = tail_reg;
                                kept_next  = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            cfifo_pkg::ST_PURGE:
            begin
                // keep odd words, compacted from the old tail onwards
                if (ram_rdata[0])
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wpos_reg;
                    ram_wdata = ram_rdata;
                    wpos_next = cfifo_pkg::next_pos(wpos_reg);
                    kept_next = kept_reg + 1'b1;
                    if (kept_reg == '0)
                    begin
                        fwd_data_next = ram_rdata;
                    end
                end
                if (left_reg != '0)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = rpos_reg;
                    rpos_next = cfifo_pkg::next_pos(rpos_reg);
                    left_next = left_reg - 1'b1;
                end
                else
                begin
                    head_next  = tail_reg;
                    tail_next  = wpos_next;
                    count_next = kept_next;
                    fwd_next   = 1'b1;
                    state_next = cfifo_pkg::ST_RESP;
                end
            end
            cfifo_pkg::ST_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.ok         = ok_reg;
                    rsp_next.head_valid = (count_reg != '0);
                    rsp_next.count      = count_reg;
                    rsp_next.is_empty   = (count_reg == '0);
                    rsp_next.is_full    = (count_reg == cfifo_pkg::FULL_COUNT);
                    if (count_reg == '0)
                    begin
                        rsp_next.head_value = '0;
                    end
                    else if (fwd_reg)
                    begin
                        rsp_next.head_value = fwd_data_reg;
                    end
                    else
                    begin
                        rsp_next.head_value = ram_rdata;
                    end
                    state_next = cfifo_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cfifo_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ hw/rtl/cfifo_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module cfifo_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/cfifo_checker.sv @@
// Port-level checker for the circular FIFO with even purge, bound to the top level
`include "assert_macros.svh"

module cfifo_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            rsp_valid,
    input logic            rsp_stall,
    input cfifo_pkg::rsp_t rsp
);

    `ASSERT_ALWAYS(a_no_beat_in_reset, clk, !rst_n |=> !rsp_valid, "result beat during reset")
    `ASSERT_CLK(a_beat_held, clk, rst_n, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "stalled result beat changed")
    `ASSERT_CLK(a_flags_match, clk, rst_n, rsp_valid |-> (rsp.is_empty == (rsp.count == '0)) && (rsp.head_valid == !rsp.is_empty), "empty or head flag disagrees with count")
    `ASSERT_CLK(a_full_match, clk, rst_n, rsp_valid |-> (rsp.count <= cfifo_pkg::FULL_COUNT) && (rsp.is_full == (rsp.count == cfifo_pkg::FULL_COUNT)), "count out of range or full flag wrong")
    `ASSERT_CLK(a_refusal_cause, clk, rst_n, rsp_valid && !rsp.ok |-> rsp.is_full || rsp.is_empty, "refused operation while neither full nor empty")

endmodule

bind circular_fifo_with_even_purge cfifo_checker u_checker (.*);
